// ===== design/lcdbar_pkg.sv =====
package lcdbar_pkg;

   localparam int MaxPages = 8;

   localparam logic CmdSetCursor = 1'b0;
   localparam logic CmdDrawColumn = 1'b1;

   localparam logic [7:0] PageCmdBase = 8'hB0;
   localparam logic [7:0] ColHighCmdBase = 8'h10;
   localparam logic [7:0] ByteFull = 8'hFF;
   localparam logic [7:0] ByteEmpty = 8'h00;

   localparam logic [1:0] StepPage = 2'd0;
   localparam logic [1:0] StepColHigh = 2'd1;
   localparam logic [1:0] StepColLow = 2'd2;
   localparam logic [1:0] StepData = 2'd3;

   localparam logic RegColumnOffset = 1'b0;

   typedef struct packed {
      logic       is_draw;
      logic [7:0] column;
      logic [2:0] page;
      logic [3:0] pages;
      logic [2:0] mark;
      logic [3:0] shift;
   } desc_type;

   typedef struct packed {
      logic       empty;
      logic       full;
      logic [1:0] count;
   } q_status_type;

endpackage

// ===== design/lcd_bar_column_sequencer.sv =====
// Bar-graph column sequencer for a page-addressed LCD controller.
// Requests enter on the req_ channel (valid/ready) and carry a command:
// set cursor, or draw one bar column at the cursor. Each request becomes a
// stream of controller bytes on the rsp_ channel, one byte per result, with
// rsp_is_data marking display data and rsp_last marking the final byte.
// A set-cursor request gives 3 bytes; a draw request of L pages gives 4L+3.
// The column offset register is written through the csr_ APB port at
// address 0 and should only be changed while the block is idle.
// An accepted request is written into the queue, and its first byte is then
// registered in the output byte register. The output sequencer emits one
// byte per cycle while the receiver is ready, and a request is 3 to 35 bytes;
// a two-entry queue accepts new requests while earlier ones are being sent.
// When the receiver stalls, the current byte holds and the sequencer waits;
// once the queue is full, req_ready drops.
// Reset clears the cursor to column 0, page 0, empties the queue and sets
// the column offset to 4.
module lcd_bar_column_sequencer
   import lcdbar_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [7:0]  req_column,
   input  logic [2:0]  req_page_line,
   input  logic [3:0]  req_bar_pages,
   input  logic [7:0]  req_bar_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_data,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [3:0]   column_offset_ff, column_offset_in;
   logic         accept;
   logic         pop;
   desc_type     new_desc;
   desc_type     head_desc;
   q_status_type q_status;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == RegColumnOffset) ? {28'd0, column_offset_ff} : 32'd0;

   always_comb begin
      column_offset_in = column_offset_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == RegColumnOffset) begin
         column_offset_in = csr_pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_offset_ff <= 4'd4;
      end else begin
         column_offset_ff <= column_offset_in;
      end
   end

   assign req_ready = !q_status.full;
   assign accept = req_valid && req_ready;

   lcdbar_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .command   (req_command),
      .column    (req_column),
      .page_line (req_page_line),
      .bar_pages (req_bar_pages),
      .bar_value (req_bar_value),
      .desc      (new_desc)
   );

   lcdbar_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_desc (new_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .status    (q_status)
   );

   lcdbar_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (!q_status.empty),
      .head_desc     (head_desc),
      .column_offset (column_offset_ff),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_is_data   (rsp_is_data),
      .rsp_last      (rsp_last)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count != 2'd3)
      else $error("queue count out of range");

   a_last_is_command: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !rsp_is_data)
      else $error("final byte of a request is a data byte");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> !pop)
      else $error("pop from empty queue");

   a_idle_output: assert property (@(posedge clock) disable iff (reset)
      q_status.empty && !rsp_valid |=> !rsp_valid)
      else $error("output appeared without a queued request");

endmodule

// ===== design/lcdbar_front.sv =====
module lcdbar_front
   import lcdbar_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       command,
   input  logic [7:0] column,
   input  logic [2:0] page_line,
   input  logic [3:0] bar_pages,
   input  logic [7:0] bar_value,
   output desc_type   desc
);

   logic [7:0] cursor_column_ff, cursor_column_in;
   logic [2:0] cursor_page_ff, cursor_page_in;
   logic [3:0] pages;
   logic [6:0] full;
   logic [6:0] value_clamped;
   logic [6:0] gap;
   logic [2:0] mark;
   logic [6:0] shift_wide;

   always_comb begin
      if (bar_pages == 4'd0) begin
         pages = 4'd1;
      end else if (bar_pages > 4'(MaxPages)) begin
         pages = 4'(MaxPages);
      end else begin
         pages = bar_pages;
      end
      full = {pages, 3'b000};
      if ({1'b0, bar_value} > {2'b00, full}) begin
         value_clamped = full;
      end else begin
         value_clamped = bar_value[6:0];
      end
      gap = full - 7'd1 - value_clamped;
      if (value_clamped < full) begin
         mark = gap[5:3];
      end else begin
         mark = 3'd0;
      end
      shift_wide = full - {1'b0, mark, 3'b000} - value_clamped;
   end

   always_comb begin
      desc.is_draw = (command == CmdDrawColumn);
      desc.pages = pages;
      desc.mark = mark;
      desc.shift = shift_wide[3:0];
      if (command == CmdDrawColumn) begin
         desc.column = cursor_column_ff;
         desc.page = cursor_page_ff;
      end else begin
         desc.column = column;
         desc.page = page_line;
      end
   end

   always_comb begin
      cursor_column_in = cursor_column_ff;
      cursor_page_in = cursor_page_ff;
      if (accept) begin
         if (command == CmdDrawColumn) begin
            cursor_column_in = cursor_column_ff + 8'd1;
         end else begin
            cursor_column_in = column;
            cursor_page_in = page_line;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_column_ff <= 8'd0;
         cursor_page_ff <= 3'd0;
      end else begin
         cursor_column_ff <= cursor_column_in;
         cursor_page_ff <= cursor_page_in;
      end
   end

endmodule

// ===== design/lcdbar_queue.sv =====
module lcdbar_queue
   import lcdbar_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  desc_type     push_desc,
   input  logic         pop,
   output desc_type     head_desc,
   output q_status_type status
);

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   assign head_desc = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == 2'd0);
   assign status.full = (count_ff == 2'd2);
   assign status.count = count_ff;

endmodule

// ===== design/lcdbar_back.sv =====
module lcdbar_back
   import lcdbar_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  desc_type   head_desc,
   input  logic [3:0] column_offset,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_data,
   output logic       rsp_last
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       is_data_ff, is_data_in;
   logic       last_ff, last_in;
   logic [1:0] step_ff, step_in;
   logic [2:0] index_ff, index_in;
   logic       pages_done_ff, pages_done_in;

   logic       advance;
   logic       emit;
   logic       final_phase;
   logic [7:0] col;
   logic [2:0] page;
   logic [7:0] addr;
   logic [7:0] data_byte;
   logic [2:0] last_index;

   assign advance = !valid_ff || rsp_ready;
   assign emit = advance && head_valid;
   assign final_phase = !head_desc.is_draw || pages_done_ff;
   assign last_index = 3'(head_desc.pages - 4'd1);

   always_comb begin
      if (final_phase) begin
         page = head_desc.page;
         col = head_desc.is_draw ? head_desc.column + 8'd1 : head_desc.column;
      end else begin
         page = head_desc.page + index_ff;
         col = head_desc.column;
      end
      addr = col + {4'b0000, column_offset};
      if (index_ff < head_desc.mark) begin
         data_byte = ByteEmpty;
      end else if (index_ff == head_desc.mark) begin
         data_byte = head_desc.shift[3] ? ByteEmpty : ByteFull << head_desc.shift[2:0];
      end else begin
         data_byte = ByteFull;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      byte_in = byte_ff;
      is_data_in = is_data_ff;
      last_in = last_ff;
      step_in = step_ff;
      index_in = index_ff;
      pages_done_in = pages_done_ff;
      pop = 1'b0;
      if (advance) begin
         valid_in = head_valid;
      end
      if (emit) begin
         is_data_in = 1'b0;
         last_in = 1'b0;
         step_in = step_ff + 2'd1;
         case (step_ff)
            StepPage: begin
               byte_in = PageCmdBase | {5'b00000, page};
            end
            StepColHigh: begin
               byte_in = ColHighCmdBase | {4'b0000, addr[7:4]};
            end
            StepColLow: begin
               byte_in = {4'b0000, addr[3:0]};
               if (final_phase) begin
                  last_in = 1'b1;
                  pop = 1'b1;
                  step_in = StepPage;
                  index_in = 3'd0;
                  pages_done_in = 1'b0;
               end
            end
            StepData: begin
               byte_in = data_byte;
               is_data_in = 1'b1;
               if (index_ff == last_index) begin
                  pages_done_in = 1'b1;
               end else begin
                  index_in = index_ff + 3'd1;
               end
            end
            default: begin
               byte_in = byte_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff <= StepPage;
         index_ff <= 3'd0;
         pages_done_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         step_ff <= step_in;
         index_ff <= index_in;
         pages_done_ff <= pages_done_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      is_data_ff <= is_data_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_is_data = is_data_ff;
   assign rsp_last = last_ff;

endmodule
